[hdl/contiguous_frame_allocator_assert.svh]
// Assertion macros for the contiguous frame allocator.
// Used by contiguous_frame_allocator.sv; no other dependencies.
`ifndef CONTIGUOUS_FRAME_ALLOCATOR_ASSERT_SVH
`define CONTIGUOUS_FRAME_ALLOCATOR_ASSERT_SVH
`ifndef SYNTH
`define CFA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cfa assertion failed");
`define CFA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cfa assertion failed");
`else
`define CFA_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define CFA_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

[hdl/cfa_pkg.sv]
// Shared types and constants of the contiguous frame allocator.
// No dependencies.
`default_nettype none
package cfa_pkg;
  localparam int FRAME_W = 20;
  localparam int COUNT_W = 11;
  localparam int ROUND_FRAMES = 16;

  typedef logic [FRAME_W-1:0] frame_t;
  typedef logic [COUNT_W-1:0] count_t;

  typedef enum logic [1:0] {
    CMD_ALLOC   = 2'd0,
    CMD_RELEASE = 2'd1,
    CMD_MARK    = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_ROOM  = 2'd1,
    ST_OUTSIDE  = 2'd2,
    ST_NOT_HEAD = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    REG_BASE    = 2'd0,
    REG_FRAMES  = 2'd1,
    REG_RESERVE = 2'd2,
    REG_NONE    = 2'd3
  } reg_idx_t;
endpackage
`default_nettype wire

[hdl/cfa_if.sv]
// Request and result channel interfaces of the frame allocator.
// Depends on cfa_pkg.
`default_nettype none
interface cfa_in_if;
  import cfa_pkg::*;
  logic   valid;
  logic   ready;
  cmd_t   command;
  count_t frame_count;
  frame_t frame_number;
  modport source (output valid, command, frame_count, frame_number, input ready);
  modport sink (input valid, command, frame_count, frame_number, output ready);
endinterface

interface cfa_out_if;
  import cfa_pkg::*;
  logic    valid;
  logic    ready;
  status_t status;
  frame_t  head_frame;
  count_t  free_count;
  modport source (output valid, status, head_frame, free_count, input ready);
  modport sink (input valid, status, head_frame, free_count, output ready);
endinterface
`default_nettype wire

[hdl/cfa_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module cfa_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end
endmodule
`default_nettype wire

[hdl/contiguous_frame_allocator.sv]
// Contiguous frame allocator: first-fit run allocation over a frame bitmap RAM.
// Depends on cfa_pkg, cfa_if, cfa_ram and contiguous_frame_allocator_assert.svh.
// Allocate reads and evaluates frames from the bottom up, then marks the run found;
// release and mark read, evaluate and write each frame touched; others go to S_FIN.
// One request at a time; one RAM port pair is walked by a single sequencer.
// Reset and each config write other than to REG_NONE clear all POOL_FRAMES frames.
`default_nettype none
`include "contiguous_frame_allocator_assert.svh"
module contiguous_frame_allocator #(
  parameter int POOL_FRAMES = 1024
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [1:0]            cfg_index,
  input  wire logic [19:0]           cfg_data,
  cfa_in_if.sink                     in_ch,
  cfa_out_if.source                  out_ch
);
  import cfa_pkg::*;

  localparam int IDX_W = $clog2(POOL_FRAMES);
  localparam int CNT_W = $clog2(POOL_FRAMES + 1);
  localparam int NW = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
  localparam int SW = FRAME_W + 1;

  typedef enum logic [5:0] {
    S_CLR  = 6'b000001,
    S_IDLE = 6'b000010,
    S_RD   = 6'b000100,
    S_EV   = 6'b001000,
    S_WR   = 6'b010000,
    S_FIN  = 6'b100000
  } state_t;

  state_t       state_r, state_nxt;
  logic [CNT_W-1:0] k_r, k_nxt, lim_r, lim_nxt, run_r, run_nxt;
  logic [CNT_W-1:0] first_r, first_nxt, free_r, free_nxt;
  cmd_t         cmd_r, cmd_nxt;
  count_t       cnt_r, cnt_nxt;
  status_t      res_st_r, res_st_nxt;
  frame_t       res_head_r, res_head_nxt;
  frame_t       base_r;
  count_t       fiu_r;
  logic         resv_r;
  logic         out_valid_r;
  status_t      out_status_r;
  frame_t       out_head_r;
  count_t       out_free_r;

  logic [NW-1:0]    masked_w, n_w;
  logic [CNT_W-1:0] n;
  logic             ram_we;
  logic [1:0]       ram_wdata, ram_rdata;
  logic             in_range;
  frame_t           idx_f;
  logic [SW-1:0]    mark_end;
  logic [CNT_W-1:0] k_inc;

  assign masked_w = NW'(fiu_r & ~count_t'(ROUND_FRAMES - 1));
  assign n_w = (masked_w > NW'(POOL_FRAMES)) ? NW'(POOL_FRAMES) : masked_w;
  assign n = CNT_W'(n_w);
  assign k_inc = k_r + CNT_W'(1);

  assign in_range = (in_ch.frame_number >= base_r) &&
                    (SW'(in_ch.frame_number) < SW'(base_r) + SW'(n));
  assign idx_f = in_ch.frame_number - base_r;
  assign mark_end = SW'(idx_f) + SW'(in_ch.frame_count);

  cfa_ram #(.WIDTH(2), .DEPTH(POOL_FRAMES)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (k_r[IDX_W-1:0]),
    .wdata (ram_wdata),
    .raddr (k_r[IDX_W-1:0]),
    .rdata (ram_rdata)
  );

  assign in_ch.ready = (state_r == S_IDLE) && !cfg_we;
  assign out_ch.valid = out_valid_r;
  assign out_ch.status = out_status_r;
  assign out_ch.head_frame = out_head_r;
  assign out_ch.free_count = out_free_r;

  always_comb begin
    state_nxt = state_r;
    k_nxt = k_r;
    lim_nxt = lim_r;
    run_nxt = run_r;
    first_nxt = first_r;
    free_nxt = free_r;
    cmd_nxt = cmd_r;
    cnt_nxt = cnt_r;
    res_st_nxt = res_st_r;
    res_head_nxt = res_head_r;
    ram_we = 1'b0;
    ram_wdata = 2'b00;
    unique case (state_r)
      S_CLR: begin
        ram_we = 1'b1;
        ram_wdata = ((k_r == '0) && resv_r && (n != '0)) ? 2'b11 : 2'b00;
        k_nxt = k_inc;
        if (k_r == CNT_W'(POOL_FRAMES - 1)) begin
          free_nxt = n - CNT_W'(resv_r && (n != '0));
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_ch.valid && in_ch.ready) begin
          cmd_nxt = in_ch.command;
          cnt_nxt = in_ch.frame_count;
          res_st_nxt = ST_OK;
          res_head_nxt = '0;
          run_nxt = '0;
          k_nxt = '0;
          state_nxt = S_FIN;
          unique case (in_ch.command)
            CMD_ALLOC: begin
              if ((in_ch.frame_count == '0) ||
                  (NW'(in_ch.frame_count) > NW'(free_r)) ||
                  (NW'(in_ch.frame_count) > n_w)) begin
                res_st_nxt = ST_NO_ROOM;
              end else begin
                state_nxt = S_RD;
              end
            end
            CMD_RELEASE, CMD_MARK: begin
              if (!in_range) begin
                res_st_nxt = ST_OUTSIDE;
              end else if ((in_ch.command == CMD_RELEASE) ||
                           (in_ch.frame_count != '0)) begin
                k_nxt = CNT_W'(idx_f);
                first_nxt = CNT_W'(idx_f);
                lim_nxt = (mark_end > SW'(n)) ? n : CNT_W'(mark_end);
                state_nxt = S_RD;
              end
            end
            CMD_NONE: begin
            end
          endcase
        end
      end
      S_RD: begin
        state_nxt = S_EV;
      end
      S_EV: begin
        state_nxt = S_RD;
        unique case (cmd_r)
          CMD_ALLOC: begin
            run_nxt = ram_rdata[1] ? '0 : run_r + CNT_W'(1);
            k_nxt = k_inc;
            if (NW'(run_nxt) == NW'(cnt_r)) begin
              first_nxt = k_inc - CNT_W'(cnt_r);
              k_nxt = k_inc - CNT_W'(cnt_r);
              lim_nxt = k_inc;
              state_nxt = S_WR;
            end else if (k_inc == n) begin
              res_st_nxt = ST_NO_ROOM;
              state_nxt = S_FIN;
            end
          end
          CMD_RELEASE: begin
            if (k_r == first_r) begin
              if (!ram_rdata[0]) begin
                res_st_nxt = ST_NOT_HEAD;
                state_nxt = S_FIN;
              end else begin
                ram_we = 1'b1;
                if (ram_rdata[1]) begin
                  free_nxt = free_r + CNT_W'(1);
                end
              end
            end else if (!ram_rdata[1] || ram_rdata[0]) begin
              state_nxt = S_FIN;
            end else begin
              ram_we = 1'b1;
              free_nxt = free_r + CNT_W'(1);
            end
            k_nxt = k_inc;
            if (k_inc == n) begin
              state_nxt = S_FIN;
            end
          end
          CMD_MARK: begin
            ram_we = 1'b1;
            ram_wdata = {1'b1, k_r == first_r};
            if (!ram_rdata[1]) begin
              free_nxt = free_r - CNT_W'(1);
            end
            k_nxt = k_inc;
            if (k_inc == lim_r) begin
              state_nxt = S_FIN;
            end
          end
          CMD_NONE: begin
            state_nxt = S_FIN;
          end
        endcase
      end
      S_WR: begin
        ram_we = 1'b1;
        ram_wdata = {1'b1, k_r == first_r};
        k_nxt = k_inc;
        if (k_inc == lim_r) begin
          free_nxt = free_r - CNT_W'(cnt_r);
          res_head_nxt = base_r + FRAME_W'(first_r);
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (!out_valid_r || out_ch.ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLR;
      end
    endcase
    if (cfg_we && (reg_idx_t'(cfg_index) != REG_NONE)) begin
      state_nxt = S_CLR;
      k_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      k_r <= '0;
      base_r <= '0;
      fiu_r <= count_t'(1024);
      resv_r <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      k_r <= k_nxt;
      if (cfg_we) begin
        unique case (reg_idx_t'(cfg_index))
          REG_BASE:    base_r <= cfg_data;
          REG_FRAMES:  fiu_r <= cfg_data[COUNT_W-1:0];
          REG_RESERVE: resv_r <= cfg_data[0];
          REG_NONE: begin
          end
        endcase
      end
      if ((state_r == S_FIN) && (!out_valid_r || out_ch.ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    lim_r <= lim_nxt;
    run_r <= run_nxt;
    first_r <= first_nxt;
    free_r <= free_nxt;
    cmd_r <= cmd_nxt;
    cnt_r <= cnt_nxt;
    res_st_r <= res_st_nxt;
    res_head_r <= res_head_nxt;
    if ((state_r == S_FIN) && (!out_valid_r || out_ch.ready)) begin
      out_status_r <= res_st_r;
      out_head_r <= res_head_r;
      out_free_r <= COUNT_W'(free_r);
    end
  end

  `CFA_ASSERT_NEXT(a_busy_after_req, clk, rst_n, in_ch.valid && in_ch.ready, !in_ch.ready)
  `CFA_ASSERT_NOW(a_free_le_pool, clk, rst_n, state_r == S_IDLE, free_r <= n)
  `CFA_ASSERT_NEXT(a_cfg_clears, clk, rst_n, cfg_we && (reg_idx_t'(cfg_index) != REG_NONE), state_r == S_CLR)
endmodule
`default_nettype wire

[bench/contiguous_frame_allocator_tb.sv]
`timescale 1ns / 1ps
// Self-checking bench for contiguous_frame_allocator: directed table, then random phases
// under several pool settings; results checked against table values or a bitmap model.
// Depends on cfa_pkg, cfa_if and the allocator RTL.
module contiguous_frame_allocator_tb;
  import cfa_pkg::*;

  localparam int MAP_FRAMES = 1024;

  typedef struct packed {
    status_t status;
    frame_t  head;
    count_t  free_cnt;
  } result_t;

  typedef struct {
    cmd_t    cmd;
    count_t  cnt;
    frame_t  frame;
    bit      typed;
    result_t want;
  } row_t;

  typedef struct {
    frame_t base;
    count_t frames;
    bit     reserve;
    int     items;
  } phase_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [1:0] cfg_index;
  logic [19:0] cfg_data;

  cfa_in_if  in_if();
  cfa_out_if out_if();

  contiguous_frame_allocator u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_if),
    .out_ch    (out_if)
  );

  frame_t  base_cfg;
  count_t  frames_cfg;
  bit      reserve_cfg;
  bit      frame_used [MAP_FRAMES];
  bit      frame_head [MAP_FRAMES];
  int unsigned free_frames;

  result_t pending_results[$];
  int      mismatches;
  int      requests_sent;
  int      results_seen;
  int      long_hold_reqs;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #100_000_000;
    $display("FAILURE");
    $finish;
  end

  function automatic int unsigned pool_size();
    int unsigned n;
    n = frames_cfg - (frames_cfg % ROUND_FRAMES);
    if (n > MAP_FRAMES) n = MAP_FRAMES;
    return n;
  endfunction

  function automatic void pool_init();
    int unsigned n;
    n = pool_size();
    for (int i = 0; i < MAP_FRAMES; i++) begin
      frame_used[i] = 1'b0;
      frame_head[i] = 1'b0;
    end
    free_frames = n;
    if (reserve_cfg && n > 0) begin
      frame_used[0] = 1'b1;
      frame_head[0] = 1'b1;
      free_frames = n - 1;
    end
  endfunction

  function automatic result_t apply_request(cmd_t c, count_t k, frame_t f);
    int unsigned n, run, i, start, idx, stop;
    bit found;
    result_t r;
    r = '{ST_OK, '0, '0};
    n = pool_size();
    case (c)
      CMD_ALLOC: begin
        if (k == 0 || k > free_frames || k > n) begin
          r.status = ST_NO_ROOM;
        end else begin
          run = 0;
          found = 0;
          for (i = 0; i < n; i++) begin
            run = frame_used[i] ? 0 : run + 1;
            if (run == k) begin
              found = 1;
              break;
            end
          end
          if (!found) begin
            r.status = ST_NO_ROOM;
          end else begin
            start = i + 1 - k;
            for (int j = start; j <= i; j++) begin
              frame_used[j] = 1'b1;
              frame_head[j] = 1'b0;
            end
            frame_head[start] = 1'b1;
            free_frames -= k;
            r.head = frame_t'(base_cfg + start);
          end
        end
      end
      CMD_RELEASE: begin
        if (f < base_cfg || f >= base_cfg + n) begin
          r.status = ST_OUTSIDE;
        end else begin
          idx = f - base_cfg;
          if (!frame_head[idx]) begin
            r.status = ST_NOT_HEAD;
          end else begin
            frame_head[idx] = 1'b0;
            if (frame_used[idx]) begin
              frame_used[idx] = 1'b0;
              free_frames++;
            end
            for (idx = idx + 1; idx < n; idx++) begin
              if (!frame_used[idx] || frame_head[idx]) break;
              frame_used[idx] = 1'b0;
              free_frames++;
            end
          end
        end
      end
      CMD_MARK: begin
        if (f < base_cfg || f >= base_cfg + n) begin
          r.status = ST_OUTSIDE;
        end else if (k != 0) begin
          idx = f - base_cfg;
          stop = idx + k;
          if (stop > n) stop = n;
          for (int j = idx; j < stop; j++) begin
            if (!frame_used[j]) begin
              frame_used[j] = 1'b1;
              free_frames--;
            end
            frame_head[j] = 1'b0;
          end
          frame_head[idx] = 1'b1;
        end
      end
      default: ;
    endcase
    r.free_cnt = count_t'(free_frames);
    return r;
  endfunction

  task automatic send(input cmd_t c, input count_t k, input frame_t f,
                      input bit typed, input result_t want);
    result_t r;
    @(negedge clk);
    in_if.valid        <= 1'b1;
    in_if.command      <= c;
    in_if.frame_count  <= k;
    in_if.frame_number <= f;
    do @(posedge clk); while (!in_if.ready);
    r = apply_request(c, k, f);
    pending_results.push_back(typed ? want : r);
    requests_sent++;
  endtask

  task automatic idle(input int cycles);
    @(negedge clk);
    in_if.valid <= 1'b0;
    repeat (cycles - 1) @(negedge clk);
  endtask

  task automatic drain();
    idle(1);
    wait (pending_results.size() == 0);
  endtask

  task automatic configure(input frame_t b, input count_t n, input bit rsv);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= REG_BASE;
    cfg_data  <= b;
    @(negedge clk);
    cfg_index <= REG_FRAMES;
    cfg_data  <= 20'(n);
    @(negedge clk);
    cfg_index <= REG_RESERVE;
    cfg_data  <= 20'(rsv);
    @(negedge clk);
    cfg_we    <= 1'b0;
    base_cfg    = b;
    frames_cfg  = n;
    reserve_cfg = rsv;
    pool_init();
  endtask

  task automatic send_random();
    int unsigned n, pick, idx;
    cmd_t c;
    count_t k;
    frame_t f;
    n = pool_size();
    pick = $urandom_range(0, 99);
    idx = $urandom_range(0, (n > 0) ? n - 1 : 0);
    c = CMD_ALLOC;
    k = count_t'($urandom_range(1, 8));
    f = frame_t'(base_cfg + idx);
    if (pick < 40) begin
      if ($urandom_range(0, 9) == 0) k = count_t'($urandom_range(0, n + 1));
    end else if (pick < 70) begin
      c = CMD_RELEASE;
      for (int j = 0; j < n; j++) begin
        if (frame_head[(idx + j) % n]) begin
          f = frame_t'(base_cfg + (idx + j) % n);
          break;
        end
      end
    end else if (pick < 80) begin
      c = CMD_MARK;
      k = count_t'($urandom_range(0, 3) == 0 ? $urandom_range(0, 2047) : $urandom_range(1, 20));
    end else if (pick < 90) begin
      c = CMD_RELEASE;
      if ($urandom_range(0, 2) == 0) f = frame_t'($urandom);
    end else begin
      c = cmd_t'($urandom_range(0, 3));
      k = count_t'($urandom);
      f = frame_t'($urandom);
    end
    send(c, k, f, 1'b0, '0);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      result_t want;
      results_seen++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result status=%0d", out_if.status);
      end else begin
        want = pending_results.pop_front();
        if (out_if.status !== want.status || out_if.head_frame !== want.head ||
            out_if.free_count !== want.free_cnt) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp st=%0d head=%h free=%0d, got st=%0d head=%h free=%0d",
                     want.status, want.head, want.free_cnt,
                     out_if.status, out_if.head_frame, out_if.free_count);
        end
      end
    end
  end

  initial begin
    int hold;
    int mode;
    int holds_done;
    hold = 0;
    mode = 0;
    holds_done = 0;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold_reqs != holds_done) begin
        holds_done = long_hold_reqs;
        hold = 400;
      end
      if ($urandom_range(0, 63) == 0) mode = $urandom_range(0, 2);
      if (hold > 0) begin
        hold--;
        out_if.ready <= 1'b0;
      end else begin
        case (mode)
          0: out_if.ready <= 1'b1;
          1: out_if.ready <= ($urandom_range(0, 3) != 0);
          default: out_if.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  row_t   table_rows[$];
  phase_t phases[$];

  initial begin
    int burst;
    cfg_we = 1'b0;
    cfg_index = REG_BASE;
    cfg_data = '0;
    in_if.valid = 1'b0;
    in_if.command = CMD_NONE;
    in_if.frame_count = '0;
    in_if.frame_number = '0;
    long_hold_reqs = 0;
    mismatches = 0;
    requests_sent = 0;
    results_seen = 0;
    base_cfg = '0;
    frames_cfg = 11'd1024;
    reserve_cfg = 1'b1;
    pool_init();

    table_rows = '{
      '{CMD_ALLOC,   11'd1,    20'd0,       1, '{ST_OK,       20'd1, 11'd1022}},
      '{CMD_ALLOC,   11'd0,    20'd0,       1, '{ST_NO_ROOM,  20'd0, 11'd1022}},
      '{CMD_ALLOC,   11'd1024, 20'd0,       1, '{ST_NO_ROOM,  20'd0, 11'd1022}},
      '{CMD_ALLOC,   11'd1022, 20'd0,       1, '{ST_OK,       20'd2, 11'd0}},
      '{CMD_ALLOC,   11'd1,    20'd0,       1, '{ST_NO_ROOM,  20'd0, 11'd0}},
      '{CMD_RELEASE, 11'd0,    20'd0,       1, '{ST_OK,       20'd0, 11'd1}},
      '{CMD_RELEASE, 11'd0,    20'd1,       1, '{ST_OK,       20'd0, 11'd2}},
      '{CMD_RELEASE, 11'd0,    20'd3,       1, '{ST_NOT_HEAD, 20'd0, 11'd2}},
      '{CMD_RELEASE, 11'd0,    20'd1024,    1, '{ST_OUTSIDE,  20'd0, 11'd2}},
      '{CMD_RELEASE, 11'd0,    20'hFFFFF,   1, '{ST_OUTSIDE,  20'd0, 11'd2}},
      '{CMD_RELEASE, 11'd0,    20'd2,       1, '{ST_OK,       20'd0, 11'd1024}},
      '{CMD_MARK,    11'd1024, 20'd1023,    1, '{ST_OK,       20'd0, 11'd1023}},
      '{CMD_MARK,    11'd1,    20'd1024,    1, '{ST_OUTSIDE,  20'd0, 11'd1023}},
      '{CMD_MARK,    11'd0,    20'd10,      1, '{ST_OK,       20'd0, 11'd1023}},
      '{CMD_MARK,    11'd10,   20'd5,       0, '0},
      '{CMD_MARK,    11'd4,    20'd8,       0, '0},
      '{CMD_RELEASE, 11'd0,    20'd5,       0, '0},
      '{CMD_RELEASE, 11'd0,    20'd8,       0, '0},
      '{CMD_NONE,    11'd2047, 20'hFFFFF,   1, '{ST_OK,       20'd0, 11'd1023}},
      '{CMD_ALLOC,   11'd2047, 20'd0,       1, '{ST_NO_ROOM,  20'd0, 11'd1023}},
      '{CMD_ALLOC,   11'd7,    20'hFFFFF,   0, '0}
    };

    phases = '{
      '{20'd0,       11'd1024, 1'b1, 200},
      '{20'h12345,   11'd64,   1'b0, 400},
      '{20'hFFFFF,   11'd16,   1'b1, 200},
      '{20'h80000,   11'd2047, 1'b0, 150},
      '{20'd5,       11'd15,   1'b1, 100},
      '{20'hABCDE,   11'd100,  1'b1, 500},
      '{20'h00010,   11'd33,   1'b0, 250}
    };

    rst_n = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (table_rows[i])
      send(table_rows[i].cmd, table_rows[i].cnt, table_rows[i].frame,
           table_rows[i].typed, table_rows[i].want);
    drain();

    foreach (phases[p]) begin
      configure(phases[p].base, phases[p].frames, phases[p].reserve);
      burst = 0;
      for (int i = 0; i < phases[p].items; i++) begin
        if (p == 1 && i == 50) long_hold_reqs++;
        if (p == 5 && i == 100) drain();
        if (burst == 0) begin
          burst = $urandom_range(1, 12);
          if ($urandom_range(0, 4) != 0) idle($urandom_range(1, 6));
        end
        burst--;
        send_random();
      end
      drain();
    end

    repeat (50) @(posedge clk);
    $display("covered %0d requests, %0d results, %0d pool settings incl. empty and wrapped",
             requests_sent, results_seen, phases.size() + 1);
    $display("mismatches: %0d", mismatches);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
